FILE: rtl/core/h2r_pkg.sv
package h2r_pkg;

    localparam int unsigned CHAN_W     = 8;
    localparam int unsigned LEVEL_W    = 16;              // Q8.8 level
    localparam int unsigned SXT_W      = 3;
    localparam int unsigned HUE6_W     = CHAN_W + SXT_W;
    localparam int unsigned STAGES     = 5;

    localparam logic [CHAN_W-1:0] FULL_SCALE     = 8'd255;
    localparam logic [CHAN_W-1:0] LOW_HALF_MAX   = 8'd127;
    localparam logic [2:0]        HUE_SCALE      = 3'd6;

    // floor(x/255) == (x * RECIP_255) >> RECIP_SHIFT for every 16-bit x
    localparam int unsigned       RECIP_W        = 16;
    localparam logic [RECIP_W-1:0] RECIP_255     = 16'd32897;
    localparam int unsigned       RECIP_SHIFT    = 23;

    // Largest level the cone can reach: 255.0 in Q8.8
    localparam logic [LEVEL_W-1:0] LEVEL_MAX     = 16'hFF00;

    typedef logic [CHAN_W-1:0]  t_chan;
    typedef logic [LEVEL_W-1:0] t_level;
    typedef logic [SXT_W-1:0]   t_sextant;

    localparam t_sextant SXT_RED_GREEN_UP   = 3'd0;
    localparam t_sextant SXT_GREEN_RED_DOWN = 3'd1;
    localparam t_sextant SXT_GREEN_BLUE_UP  = 3'd2;
    localparam t_sextant SXT_BLUE_GREEN_DN  = 3'd3;
    localparam t_sextant SXT_BLUE_RED_UP    = 3'd4;

endpackage

FILE: rtl/core/h2r_hsl_if.sv
interface h2r_hsl_if;
    logic          valid;
    logic          ready;
    h2r_pkg::t_chan hue;
    h2r_pkg::t_chan saturation;
    h2r_pkg::t_chan lightness;

    modport source (output valid, output hue, output saturation, output lightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input lightness,
                    output ready);
endinterface

FILE: rtl/core/h2r_rgb_if.sv
interface h2r_rgb_if;
    logic          valid;
    logic          ready;
    h2r_pkg::t_chan red;
    h2r_pkg::t_chan green;
    h2r_pkg::t_chan blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

FILE: rtl/core/h2r_div255.sv
// Divide a 16-bit level product by 255 through a reciprocal multiply.
module h2r_div255 (
    input  h2r_pkg::t_level i_num,
    output h2r_pkg::t_chan  o_quo
);
    logic [h2r_pkg::LEVEL_W+h2r_pkg::RECIP_W-1:0] prod;

    assign prod  = i_num * h2r_pkg::RECIP_255;
    assign o_quo = prod[h2r_pkg::RECIP_SHIFT +: h2r_pkg::CHAN_W];
endmodule

FILE: rtl/core/hsl_to_rgb_converter.sv
// HSL to RGB converter, 8 bits per channel.
// Accepted items pass through stages 1 to 5 in order; stage 5 is the output register.
// Throughput: one item per clock while the output is not stalled; five register stages, each with its own valid bit.
// Backpressure stalls only the stages that are full, so bubbles are squeezed out.
// Reset (i_rst_n, synchronous, active low) empties every stage; no other state.
module hsl_to_rgb_converter (
    input  logic             i_clk,
    input  logic             i_rst_n,
    h2r_hsl_if.sink          i_hsl,
    h2r_rgb_if.source        o_rgb
);

    // Stage valid bits and load enables. A stage loads when it is empty or
    // when the stage after it moves on.
    logic [h2r_pkg::STAGES-1:0] r_vld;
    logic [h2r_pkg::STAGES-1:0] stg_en;

    always_comb begin
        stg_en[h2r_pkg::STAGES-1] = !r_vld[h2r_pkg::STAGES-1] || o_rgb.ready;
        for (int k = h2r_pkg::STAGES - 2; k >= 0; k--) begin
            stg_en[k] = !r_vld[k] || stg_en[k+1];
        end
    end

    assign i_hsl.ready = stg_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stg_en[0]) begin
                r_vld[0] <= i_hsl.valid;
            end
            for (int k = 1; k < h2r_pkg::STAGES; k++) begin
                if (stg_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: cone product P, so that the maximum level is P + P/255.
    //   dark half  (L <= 127): P = L * (255 + S)
    //   light half (L >= 128): P = 255*L + S*(255 - L)
    // Hue times six splits into a sextant and an 8-bit fraction.
    // ------------------------------------------------------------------
    logic                         s1_low;
    h2r_pkg::t_chan               s1_a;
    logic [h2r_pkg::CHAN_W:0]     s1_b;
    logic [h2r_pkg::LEVEL_W:0]    s1_base;
    logic [h2r_pkg::LEVEL_W:0]    s1_sum;
    logic [h2r_pkg::HUE6_W-1:0]   s1_hue6;
    h2r_pkg::t_level              n_s1_p;

    h2r_pkg::t_level              r_s1_p;
    h2r_pkg::t_chan               r_s1_lit;
    h2r_pkg::t_sextant            r_s1_sxt;
    h2r_pkg::t_chan               r_s1_frac;

    always_comb begin
        s1_low  = (i_hsl.lightness <= h2r_pkg::LOW_HALF_MAX);
        s1_a    = s1_low ? i_hsl.lightness : (h2r_pkg::FULL_SCALE - i_hsl.lightness);
        s1_b    = s1_low ? ({1'b0, h2r_pkg::FULL_SCALE} + {1'b0, i_hsl.saturation})
                         : {1'b0, i_hsl.saturation};
        s1_base = s1_low ? '0
                         : {{(h2r_pkg::LEVEL_W+1-h2r_pkg::CHAN_W){1'b0}}, h2r_pkg::FULL_SCALE}
                           * {{(h2r_pkg::LEVEL_W+1-h2r_pkg::CHAN_W){1'b0}}, i_hsl.lightness};
        s1_sum  = {{(h2r_pkg::LEVEL_W+1-h2r_pkg::CHAN_W){1'b0}}, s1_a}
                  * {{(h2r_pkg::LEVEL_W-h2r_pkg::CHAN_W){1'b0}}, s1_b} + s1_base;
        // P tops out at 255*255, so it fits the level width
        n_s1_p  = s1_sum[h2r_pkg::LEVEL_W-1:0];
        s1_hue6 = {{h2r_pkg::SXT_W{1'b0}}, i_hsl.hue}
                  * {{h2r_pkg::CHAN_W{1'b0}}, h2r_pkg::HUE_SCALE};
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[0]) begin
            r_s1_p    <= n_s1_p;
            r_s1_lit  <= i_hsl.lightness;
            r_s1_sxt  <= s1_hue6[h2r_pkg::HUE6_W-1 -: h2r_pkg::SXT_W];
            r_s1_frac <= s1_hue6[h2r_pkg::CHAN_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: V = floor(256*P/255) = P + floor(P/255), in Q8.8.
    // ------------------------------------------------------------------
    h2r_pkg::t_chan    s2_quo;
    h2r_pkg::t_level   n_s2_vmax;

    h2r_pkg::t_level   r_s2_vmax;
    h2r_pkg::t_chan    r_s2_lit;
    h2r_pkg::t_sextant r_s2_sxt;
    h2r_pkg::t_chan    r_s2_frac;

    h2r_div255 u_div255 (
        .i_num (r_s1_p),
        .o_quo (s2_quo)
    );

    assign n_s2_vmax = r_s1_p + h2r_pkg::LEVEL_W'(s2_quo);

    always_ff @(posedge i_clk) begin
        if (stg_en[1]) begin
            r_s2_vmax <= n_s2_vmax;
            r_s2_lit  <= r_s1_lit;
            r_s2_sxt  <= r_s1_sxt;
            r_s2_frac <= r_s1_frac;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: M = 2L - V, clamped to [0, V]; span = V - M.
    // ------------------------------------------------------------------
    logic [h2r_pkg::LEVEL_W:0] s3_two_l;
    logic [h2r_pkg::LEVEL_W:0] s3_diff;
    h2r_pkg::t_level           n_s3_vmin;

    h2r_pkg::t_level   r_s3_vmin;
    h2r_pkg::t_level   r_s3_vmax;
    h2r_pkg::t_level   r_s3_span;
    h2r_pkg::t_sextant r_s3_sxt;
    h2r_pkg::t_chan    r_s3_frac;

    always_comb begin
        s3_two_l = {r_s2_lit, {(h2r_pkg::LEVEL_W+1-h2r_pkg::CHAN_W){1'b0}}};
        s3_diff  = s3_two_l - {1'b0, r_s2_vmax};
        if (s3_two_l <= {1'b0, r_s2_vmax}) begin
            n_s3_vmin = '0;
        end else if (s3_diff > {1'b0, r_s2_vmax}) begin
            n_s3_vmin = r_s2_vmax;
        end else begin
            n_s3_vmin = s3_diff[h2r_pkg::LEVEL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[2]) begin
            r_s3_vmin <= n_s3_vmin;
            r_s3_vmax <= r_s2_vmax;
            r_s3_span <= r_s2_vmax - n_s3_vmin;
            r_s3_sxt  <= r_s2_sxt;
            r_s3_frac <= r_s2_frac;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: ramp = (span * frac) >> 8.
    // ------------------------------------------------------------------
    logic [h2r_pkg::LEVEL_W+h2r_pkg::CHAN_W-1:0] s4_prod;

    h2r_pkg::t_level   r_s4_ramp;
    h2r_pkg::t_level   r_s4_vmin;
    h2r_pkg::t_level   r_s4_vmax;
    h2r_pkg::t_sextant r_s4_sxt;

    assign s4_prod = r_s3_span * r_s3_frac;

    always_ff @(posedge i_clk) begin
        if (stg_en[3]) begin
            r_s4_ramp <= s4_prod[h2r_pkg::CHAN_W +: h2r_pkg::LEVEL_W];
            r_s4_vmin <= r_s3_vmin;
            r_s4_vmax <= r_s3_vmax;
            r_s4_sxt  <= r_s3_sxt;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: build rising and falling levels, route them by sextant and
    // keep the integer part. Every level stays within V <= 255.0, so the
    // upper byte needs no clamp. This is also the output register.
    // ------------------------------------------------------------------
    h2r_pkg::t_level s5_rise;
    h2r_pkg::t_level s5_fall;
    h2r_pkg::t_level s5_r;
    h2r_pkg::t_level s5_g;
    h2r_pkg::t_level s5_b;

    h2r_pkg::t_chan  r_red;
    h2r_pkg::t_chan  r_green;
    h2r_pkg::t_chan  r_blue;

    always_comb begin
        s5_rise = r_s4_vmin + r_s4_ramp;
        s5_fall = r_s4_vmax - r_s4_ramp;
        case (r_s4_sxt)
            h2r_pkg::SXT_RED_GREEN_UP: begin
                s5_r = r_s4_vmax; s5_g = s5_rise;   s5_b = r_s4_vmin;
            end
            h2r_pkg::SXT_GREEN_RED_DOWN: begin
                s5_r = s5_fall;   s5_g = r_s4_vmax; s5_b = r_s4_vmin;
            end
            h2r_pkg::SXT_GREEN_BLUE_UP: begin
                s5_r = r_s4_vmin; s5_g = r_s4_vmax; s5_b = s5_rise;
            end
            h2r_pkg::SXT_BLUE_GREEN_DN: begin
                s5_r = r_s4_vmin; s5_g = s5_fall;   s5_b = r_s4_vmax;
            end
            h2r_pkg::SXT_BLUE_RED_UP: begin
                s5_r = s5_rise;   s5_g = r_s4_vmin; s5_b = r_s4_vmax;
            end
            default: begin
                // last sextant: blue falls toward red
                s5_r = r_s4_vmax; s5_g = r_s4_vmin; s5_b = s5_fall;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[4]) begin
            r_red   <= s5_r[h2r_pkg::LEVEL_W-1 -: h2r_pkg::CHAN_W];
            r_green <= s5_g[h2r_pkg::LEVEL_W-1 -: h2r_pkg::CHAN_W];
            r_blue  <= s5_b[h2r_pkg::LEVEL_W-1 -: h2r_pkg::CHAN_W];
        end
    end

    assign o_rgb.valid = r_vld[h2r_pkg::STAGES-1];
    assign o_rgb.red   = r_red;
    assign o_rgb.green = r_green;
    assign o_rgb.blue  = r_blue;

`ifndef SYNTHESIS
    // Input holds off only when every stage is full.
    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_hsl.ready |-> (&r_vld))
        else $error("input blocked while a stage is empty");

    // The maximum level never passes 255.0.
    a_vmax_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] |-> (r_s2_vmax <= h2r_pkg::LEVEL_MAX))
        else $error("maximum level out of range");

    // Minimum and span stay consistent with the maximum.
    a_vmin_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> ((r_s3_vmin <= r_s3_vmax) && (r_s3_vmin + r_s3_span == r_s3_vmax)))
        else $error("minimum level above maximum");

    // A stalled output stage keeps the stage before it from advancing.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[4] && !o_rgb.ready && r_vld[3]) |=> (r_vld[3] && $stable(r_s4_ramp)))
        else $error("stage 4 lost its item under stall");
`endif

endmodule
